@@ hw/rtl/gbid_pkg.sv @@
// ----------------------------------------------------------------------------
// gbid_pkg
// Shared types and constants of the GPIO bank with interrupt detection:
// bus op codes, word register map, stream packing and the result record.
// ----------------------------------------------------------------------------
package gbid_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned ADDR_W    = 7;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 104;

  localparam logic [WORD_W-1:0] REVISION_VALUE = 32'h5060_0801;

  typedef enum logic [OP_W-1:0] {
    OP_NONE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } gbid_op_e;

  localparam logic [ADDR_W-1:0] ADDR_REVISION    = 7'd0;
  localparam logic [ADDR_W-1:0] ADDR_RAW_STATUS0 = 7'd9;
  localparam logic [ADDR_W-1:0] ADDR_RAW_STATUS1 = 7'd10;
  localparam logic [ADDR_W-1:0] ADDR_STATUS0     = 7'd11;
  localparam logic [ADDR_W-1:0] ADDR_STATUS1     = 7'd12;
  localparam logic [ADDR_W-1:0] ADDR_EN_SET0     = 7'd13;
  localparam logic [ADDR_W-1:0] ADDR_EN_SET1     = 7'd14;
  localparam logic [ADDR_W-1:0] ADDR_EN_CLR0     = 7'd15;
  localparam logic [ADDR_W-1:0] ADDR_EN_CLR1     = 7'd16;
  localparam logic [ADDR_W-1:0] ADDR_DIRECTION   = 7'd77;
  localparam logic [ADDR_W-1:0] ADDR_DATA_IN     = 7'd78;
  localparam logic [ADDR_W-1:0] ADDR_DATA_OUT    = 7'd79;
  localparam logic [ADDR_W-1:0] ADDR_DET_LOW     = 7'd80;
  localparam logic [ADDR_W-1:0] ADDR_DET_HIGH    = 7'd81;
  localparam logic [ADDR_W-1:0] ADDR_DET_RISE    = 7'd82;
  localparam logic [ADDR_W-1:0] ADDR_DET_FALL    = 7'd83;
  localparam logic [ADDR_W-1:0] ADDR_CLR_OUT     = 7'd100;
  localparam logic [ADDR_W-1:0] ADDR_SET_OUT     = 7'd101;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] word_address;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] pins_in;
  } gbid_req_t;

  typedef struct packed {
    logic              irq_line1;
    logic              irq_line0;
    logic [WORD_W-1:0] pins_input_mode;
    logic [WORD_W-1:0] pins_out;
    logic [WORD_W-1:0] read_data;
  } gbid_result_t;

endpackage

@@ hw/rtl/gbid_regs.sv @@
// ----------------------------------------------------------------------------
// gbid_regs
// Register file and event detector of the GPIO bank. Applies one bus access
// and one pin sample per accepted transaction and presents the result.
// ----------------------------------------------------------------------------
module gbid_regs #(
  parameter int unsigned PIN_COUNT = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  input  gbid_pkg::gbid_req_t   req_i,
  output gbid_pkg::gbid_result_t result_o
);
  import gbid_pkg::*;

  logic [PIN_COUNT-1:0] dir_q, dir_d;
  logic [PIN_COUNT-1:0] latch_q, latch_d;
  logic [PIN_COUNT-1:0] sampled_q, sampled_d;
  logic [PIN_COUNT-1:0] prev_q, prev_d;
  logic [PIN_COUNT-1:0] det_low_q, det_low_d;
  logic [PIN_COUNT-1:0] det_high_q, det_high_d;
  logic [PIN_COUNT-1:0] det_rise_q, det_rise_d;
  logic [PIN_COUNT-1:0] det_fall_q, det_fall_d;
  logic [1:0][PIN_COUNT-1:0] irq_en_q, irq_en_d;
  logic [1:0][PIN_COUNT-1:0] raw_q, raw_d;

  logic [PIN_COUNT-1:0] wdata;
  logic [PIN_COUNT-1:0] pins;
  logic [PIN_COUNT-1:0] events;
  logic [WORD_W-1:0]    rdata;
  logic                 do_read;
  logic                 do_write;

  assign wdata    = req_i.write_data[PIN_COUNT-1:0];
  assign pins     = req_i.pins_in[PIN_COUNT-1:0];
  assign do_read  = req_valid_i && (req_i.op == OP_READ);
  assign do_write = req_valid_i && (req_i.op == OP_WRITE);

  always_comb begin
    case (req_i.word_address)
      ADDR_REVISION:    rdata = REVISION_VALUE;
      ADDR_RAW_STATUS0: rdata = WORD_W'(raw_q[0]);
      ADDR_RAW_STATUS1: rdata = WORD_W'(raw_q[1]);
      ADDR_STATUS0:     rdata = WORD_W'(raw_q[0] & irq_en_q[0]);
      ADDR_STATUS1:     rdata = WORD_W'(raw_q[1] & irq_en_q[1]);
      ADDR_EN_SET0,
      ADDR_EN_CLR0:     rdata = WORD_W'(irq_en_q[0]);
      ADDR_EN_SET1,
      ADDR_EN_CLR1:     rdata = WORD_W'(irq_en_q[1]);
      ADDR_DIRECTION:   rdata = WORD_W'(dir_q);
      ADDR_DATA_IN:     rdata = WORD_W'(sampled_q);
      ADDR_DATA_OUT,
      ADDR_CLR_OUT,
      ADDR_SET_OUT:     rdata = WORD_W'(latch_q);
      ADDR_DET_LOW:     rdata = WORD_W'(det_low_q);
      ADDR_DET_HIGH:    rdata = WORD_W'(det_high_q);
      ADDR_DET_RISE:    rdata = WORD_W'(det_rise_q);
      ADDR_DET_FALL:    rdata = WORD_W'(det_fall_q);
      default:          rdata = '0;
    endcase
  end

  always_comb begin
    dir_d      = dir_q;
    latch_d    = latch_q;
    det_low_d  = det_low_q;
    det_high_d = det_high_q;
    det_rise_d = det_rise_q;
    det_fall_d = det_fall_q;
    irq_en_d   = irq_en_q;
    raw_d      = raw_q;
    sampled_d  = sampled_q;
    prev_d     = prev_q;
    events     = '0;

    if (do_write) begin
      case (req_i.word_address)
        ADDR_RAW_STATUS0: raw_d[0]    = raw_q[0] | wdata;
        ADDR_RAW_STATUS1: raw_d[1]    = raw_q[1] | wdata;
        ADDR_STATUS0:     raw_d[0]    = raw_q[0] & ~wdata;
        ADDR_STATUS1:     raw_d[1]    = raw_q[1] & ~wdata;
        ADDR_EN_SET0:     irq_en_d[0] = irq_en_q[0] | wdata;
        ADDR_EN_SET1:     irq_en_d[1] = irq_en_q[1] | wdata;
        ADDR_EN_CLR0:     irq_en_d[0] = irq_en_q[0] & ~wdata;
        ADDR_EN_CLR1:     irq_en_d[1] = irq_en_q[1] & ~wdata;
        ADDR_DIRECTION:   dir_d       = wdata;
        ADDR_DATA_OUT:    latch_d     = wdata;
        ADDR_DET_LOW:     det_low_d   = wdata;
        ADDR_DET_HIGH:    det_high_d  = wdata;
        ADDR_DET_RISE:    det_rise_d  = wdata;
        ADDR_DET_FALL:    det_fall_d  = wdata;
        ADDR_CLR_OUT:     latch_d     = latch_q & ~wdata;
        ADDR_SET_OUT:     latch_d     = latch_q | wdata;
        default:          ;
      endcase
    end

    if (req_valid_i) begin
      prev_d    = sampled_q;
      sampled_d = pins;
      events    = (~pins & det_low_d)
                | (pins & det_high_d)
                | (pins & ~sampled_q & det_rise_d)
                | (~pins & sampled_q & det_fall_d);
      raw_d[0]  = raw_d[0] | events;
      raw_d[1]  = raw_d[1] | events;
    end
  end

  always_comb begin
    result_o.read_data       = do_read ? rdata : '0;
    result_o.pins_out        = WORD_W'(latch_d);
    result_o.pins_input_mode = WORD_W'(dir_d);
    result_o.irq_line0       = |(raw_d[0] & irq_en_d[0]);
    result_o.irq_line1       = |(raw_d[1] & irq_en_d[1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q      <= '1;
      latch_q    <= '0;
      sampled_q  <= '0;
      prev_q     <= '0;
      det_low_q  <= '0;
      det_high_q <= '0;
      det_rise_q <= '0;
      det_fall_q <= '0;
      irq_en_q   <= '0;
      raw_q      <= '0;
    end else begin
      dir_q      <= dir_d;
      latch_q    <= latch_d;
      sampled_q  <= sampled_d;
      prev_q     <= prev_d;
      det_low_q  <= det_low_d;
      det_high_q <= det_high_d;
      det_rise_q <= det_rise_d;
      det_fall_q <= det_fall_d;
      irq_en_q   <= irq_en_d;
      raw_q      <= raw_d;
    end
  end

endmodule

@@ hw/rtl/gpio_bank_with_interrupt_detect_core.sv @@
// ----------------------------------------------------------------------------
// gpio_bank_with_interrupt_detect_core
// Streaming GPIO bank: one bus access plus pin sample in, one result out.
// Each result is registered into the output buffer when its transaction is accepted.
// Throughput: one transaction per cycle while the skid entry is empty, set by the single register update.
// A two-entry output buffer keeps input flowing while one result waits.
// Reset: direction all inputs, every other register cleared and the buffer emptied.
// ----------------------------------------------------------------------------
module gpio_bank_with_interrupt_detect_core #(
  parameter int unsigned PIN_COUNT = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // op[1:0], word_address[8:2], write_data[40:9], pins_in[72:41], zero fill
  input  logic [gbid_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // read_data[31:0], pins_out[63:32], pins_input_mode[95:64],
  // irq_line0[96], irq_line1[97], zero fill
  output logic [gbid_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);
  import gbid_pkg::*;

  localparam int unsigned RES_W = $bits(gbid_result_t);

  gbid_req_t    req;
  gbid_result_t result;
  logic         accept;
  logic         pop;

  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  gbid_result_t out_data_q, out_data_d;
  gbid_result_t skid_data_q, skid_data_d;

  assign req.op           = s_axis_tdata_i[1:0];
  assign req.word_address = s_axis_tdata_i[8:2];
  assign req.write_data   = s_axis_tdata_i[40:9];
  assign req.pins_in      = s_axis_tdata_i[72:41];

  assign s_axis_tready_o = !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = out_valid_q && m_axis_tready_i;

  gbid_regs #(
    .PIN_COUNT(PIN_COUNT)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(accept),
    .req_i      (req),
    .result_o   (result)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (accept) begin
      if (out_valid_q && !pop) begin
        skid_data_d  = result;
        skid_valid_d = 1'b1;
      end else begin
        out_data_d  = result;
        out_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(out_data_q);

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without an output entry");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready_i && accept))
    else $error("skid entry filled without a stalled output");

  a_out_held_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> out_valid_q)
    else $error("waiting result dropped");

  a_res_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (m_axis_tdata_o[OUT_DATA_W-1:RES_W] == '0))
    else $error("output fill bits not zero");

endmodule
